// ===== hdl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// shared constants, codes and types of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  // default sizing
  localparam int PLE_CAPACITY     = 64;
  localparam int PLE_HANDLE_WIDTH = 16;
  // cells folded into one register of the read tree
  localparam int PLE_GROUP        = 32;

  // request operations
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;
  localparam logic [1:0] OP_APPEND = 2'd3;

  // result status
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at pos, shift upper part up
    logic rem;  // close the slot at pos, shift upper part down
  } ple_cmd_t;

endpackage

// ===== hdl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: holds a handle, takes from a neighbor on insert or remove
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int CAPACITY     = 64,
  parameter int HANDLE_WIDTH = 16,
  parameter int IDX          = 0
) (
  input  logic                              clk,
  input  ple_pkg::ple_cmd_t                 cmd_i,
  input  logic [$clog2(CAPACITY+1)-1:0]     pos_i,
  input  logic [HANDLE_WIDTH-1:0]           handle_i,
  input  logic [HANDLE_WIDTH-1:0]           left_i,
  input  logic [HANDLE_WIDTH-1:0]           right_i,
  output logic [HANDLE_WIDTH-1:0]           entry_o,
  output logic [HANDLE_WIDTH-1:0]           rd_o
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  logic [HANDLE_WIDTH-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (cmd_i.ins) begin
      if (IDX_V == pos_i) begin
        entry_r <= handle_i;
      end else if (IDX_V > pos_i) begin
        entry_r <= left_i;
      end
    end else if (cmd_i.rem) begin
      if (IDX_V >= pos_i) begin
        entry_r <= right_i;
      end
    end
  end

  assign entry_o = entry_r;
  // masked read tap, or-ed together by the read tree
  assign rd_o    = (IDX_V == pos_i) ? entry_r : '0;

endmodule

// ===== hdl/ple_rdtree.sv =====
// ----------------------------------------------------------------------------
// ple_rdtree
// two-level or tree over the cell read taps, first level registered
// ----------------------------------------------------------------------------
module ple_rdtree #(
  parameter int N     = 64,
  parameter int W     = 16,
  parameter int GROUP = 32
) (
  input  logic         clk,
  input  logic [W-1:0] data_i [N],
  output logic [W-1:0] result_o
);
  import ple_pkg::*;

  localparam int NG = (N + GROUP - 1) / GROUP;

  logic [W-1:0] pad   [NG*GROUP];
  logic [W-1:0] grp_r [NG];

  for (genvar i = 0; i < NG*GROUP; i++) begin : g_pad
    if (i < N) begin : g_live
      assign pad[i] = data_i[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_ff @(posedge clk) begin
      logic [W-1:0] acc;
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        acc = acc | pad[g*GROUP + k];
      end
      grp_r[g] <= acc;
    end
  end

  always_comb begin
    result_o = '0;
    for (int g = 0; g < NG; g++) begin
      result_o = result_o | grp_r[g];
    end
  end

endmodule

// ===== hdl/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// ordered list of handles with insert, remove, get and append by position
// ----------------------------------------------------------------------------
// usage
//   in_ channel: one request word (operation, position, handle_in) is taken
//   at an edge with in_valid high and in_stall low. in_stall is high while
//   a request is in work, so one request is held at a time.
//   out_ channel: one result word (status, handle_out, entry_count) per
//   request, held in an output register until out_stall is low.
//   result: the request is captured, then an execute step in which the cell
//   row shifts while the read tree registers its first level, then a final
//   step that folds the groups into the output register.
//   one request at a time: the next word is taken only in the idle state,
//   with in_stall low, after the execute and final steps.
//   a stalled result does not block the next request: it runs through the
//   cell row and waits in the final step until the output register frees.
//   reset: entry count cleared, no result pending; cell contents are left
//   as they are, only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
  parameter int CAPACITY     = ple_pkg::PLE_CAPACITY,
  parameter int HANDLE_WIDTH = ple_pkg::PLE_HANDLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [$clog2(CAPACITY+1)-1:0] in_position,
  input  logic [HANDLE_WIDTH-1:0]       in_handle_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [HANDLE_WIDTH-1:0]       out_handle_out,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_V = CW'(CAPACITY);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_EXEC = 2'd1;  // cells shift, read tree first level
  localparam logic [1:0] S_FIN  = 2'd2;  // result into output register

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;

  // captured request
  logic [1:0]              req_op_r;
  logic [CW-1:0]           req_pos_r;
  logic [HANDLE_WIDTH-1:0] req_h_r;
  logic [1:0]              req_st_r;

  // result register
  logic                    out_valid_r;
  logic [1:0]              out_st_r;
  logic [HANDLE_WIDTH-1:0] out_h_r;
  logic [CW-1:0]           out_cnt_r;

  logic                    in_acc;
  logic                    out_free;
  logic [1:0]              new_st;
  logic [CW-1:0]           new_pos;
  ple_cmd_t                cmd;

  logic [HANDLE_WIDTH-1:0] entry [CAPACITY];
  logic [HANDLE_WIDTH-1:0] rd    [CAPACITY];
  logic [HANDLE_WIDTH-1:0] rd_word;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // status check against the count at acceptance; range before full
  always_comb begin
    new_st  = ST_DONE;
    new_pos = in_position;
    case (in_operation)
      OP_INSERT: begin
        if (in_position > count_r) begin
          new_st = ST_RANGE;
        end else if (count_r >= CAP_V) begin
          new_st = ST_FULL;
        end
      end
      OP_REMOVE, OP_GET: begin
        if (in_position >= count_r) begin
          new_st = ST_RANGE;
        end
      end
      OP_APPEND: begin
        // append is an insert at the tail
        new_pos = count_r;
        if (count_r >= CAP_V) begin
          new_st = ST_FULL;
        end
      end
      default: new_st = ST_RANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op_r  <= in_operation;
      req_pos_r <= new_pos;
      req_h_r   <= in_handle_in;
      req_st_r  <= new_st;
    end
  end

  // shift commands go out only in the execute cycle of a good request
  always_comb begin
    cmd.ins = (state_r == S_EXEC) && (req_st_r == ST_DONE) &&
              ((req_op_r == OP_INSERT) || (req_op_r == OP_APPEND));
    cmd.rem = (state_r == S_EXEC) && (req_st_r == ST_DONE) &&
              (req_op_r == OP_REMOVE);
  end

  // row of cells, each linked to its neighbors, zero beyond the ends
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [HANDLE_WIDTH-1:0] left_w;
    logic [HANDLE_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entry[i+1];
    end

    ple_cell #(
      .CAPACITY     (CAPACITY),
      .HANDLE_WIDTH (HANDLE_WIDTH),
      .IDX          (i)
    ) u_cell (
      .clk      (clk),
      .cmd_i    (cmd),
      .pos_i    (req_pos_r),
      .handle_i (req_h_r),
      .left_i   (left_w),
      .right_i  (right_w),
      .entry_o  (entry[i]),
      .rd_o     (rd[i])
    );
  end

  // get path: taps are sampled in the execute cycle, before any shift
  ple_rdtree #(
    .N     (CAPACITY),
    .W     (HANDLE_WIDTH),
    .GROUP (PLE_GROUP)
  ) u_rdtree (
    .clk      (clk),
    .data_i   (rd),
    .result_o (rd_word)
  );

  // sequencer and count
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
        if (cmd.ins) begin
          count_nxt = count_r + CW'(1);
        end else if (cmd.rem) begin
          count_nxt = count_r - CW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_st_r  <= req_st_r;
      out_h_r   <= ((req_op_r == OP_GET) && (req_st_r == ST_DONE)) ? rd_word : '0;
      out_cnt_r <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_handle_out  = out_h_r;
  assign out_entry_count = out_cnt_r;

  // count stays within the capacity
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_V)
    else $error("entry count above capacity");

  // count steps by one, and only in the execute cycle; only the latter is checked here
  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> $stable(count_r))
    else $error("entry count changed outside execute");

  // a new result is only loaded from the final step
  a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && (state_r != S_FIN) |=> !out_valid_r)
    else $error("result shown without a finished request");

  // a full report only comes with a full list
  a_full_cnt : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_FULL) |-> (out_cnt_r == CAP_V))
    else $error("full status with room left");

  // execute always follows an accepted request
  a_exec_seq : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_EXEC))
    else $error("accepted request not executed");

endmodule
